### design/date_distance_in_days_macros.svh
// ----------------------------------------------------------------------------
// Date distance assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DATE_DISTANCE_IN_DAYS_MACROS_SVH
`define DATE_DISTANCE_IN_DAYS_MACROS_SVH

// Same-cycle implication.
`define DDID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define DDID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/ddid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date distance package
// Field types, calendar constants and small arithmetic helpers.
// ----------------------------------------------------------------------------
package ddid_pkg;

    typedef logic [4:0]         t_day;
    typedef logic [3:0]         t_month;
    typedef logic [13:0]        t_year;
    typedef logic signed [22:0] t_dist;

    // Year offset minus one: keeps every day number positive.
    localparam logic [14:0] YEAR_BIAS    = 15'd399;
    localparam logic [22:0] DAYS_IN_YEAR = 23'd365;
    localparam logic [14:0] CENTURY      = 15'd100;
    localparam logic [3:0]  MONTHS       = 4'd12;
    localparam logic [3:0]  FEBRUARY     = 4'd2;

    // floor(x * 2^-17 * 5243) == floor(x / 25) for x below 2^13
    localparam logic [25:0] DIV25_RECIP  = 26'd5243;

    localparam logic signed [23:0] DIST_HI = 24'sd4194303;
    localparam logic signed [23:0] DIST_LO = -24'sd4194304;

    function automatic logic [7:0] f_div25(input logic [12:0] x);
        logic [25:0] prod;
        prod = 26'(x) * DIV25_RECIP;
        return prod[24:17];
    endfunction

    function automatic logic [8:0] f_days_before(input t_month m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### design/date_distance_in_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date distance in days
// Signed day count from a first to a second Gregorian date.
// ----------------------------------------------------------------------------
// Four-stage pipeline: a date pair is taken every cycle unless the output is
// stalled. Stage one divides the shifted years by 100 and 400 through constant
// reciprocal multiplies, stage two forms the day number of the year start and
// the in-year offset, stage three adds them, stage four subtracts, saturates
// to 23 bits and registers the result. A month outside 1 to 12 in either date
// gives status 1 and distance 0. Day values are used unchecked. When the
// output is stalled all stages hold, and o_stall is high exactly while a
// result waits under i_stall.
`include "date_distance_in_days_macros.svh"

module date_distance_in_days (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ddid_pkg::t_day    i_first_day,
    input  ddid_pkg::t_month  i_first_month,
    input  ddid_pkg::t_year   i_first_year,
    input  ddid_pkg::t_day    i_second_day,
    input  ddid_pkg::t_month  i_second_month,
    input  ddid_pkg::t_year   i_second_year,
    output logic              o_valid,
    input  logic              i_stall,
    output ddid_pkg::t_dist   o_distance_days,
    output logic              o_status
);
    import ddid_pkg::*;

    logic       en;

    t_day       w_day   [2];
    t_month     w_month [2];
    t_year      w_year  [2];

    // stage 1
    logic        r1_valid;
    logic        r1_bad;
    logic [14:0] r1_p     [2];
    t_year       r1_year  [2];
    logic [7:0]  r1_q100p [2];
    logic [5:0]  r1_q400p [2];
    logic [7:0]  r1_q100y [2];
    logic [8:0]  r1_dbm   [2];
    logic        r1_late  [2];
    t_day        r1_day   [2];
    logic        n_bad;
    logic [14:0] n_p      [2];
    logic [7:0]  n_q100p  [2];
    logic [7:0]  n_q400p  [2];
    logic [7:0]  n_q100y  [2];

    // stage 2
    logic        r2_valid;
    logic        r2_bad;
    logic [22:0] r2_base  [2];
    logic [8:0]  r2_add   [2];
    logic [22:0] n_base   [2];
    logic [8:0]  n_add    [2];
    logic        w_century [2];
    logic        w_leap    [2];

    // stage 3
    logic        r3_valid;
    logic        r3_bad;
    logic [22:0] r3_n     [2];
    logic [22:0] n_n      [2];

    // stage 4
    logic signed [23:0] w_diff;
    t_dist              n_dist;

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    assign w_day[0]   = i_first_day;
    assign w_day[1]   = i_second_day;
    assign w_month[0] = i_first_month;
    assign w_month[1] = i_second_month;
    assign w_year[0]  = i_first_year;
    assign w_year[1]  = i_second_year;

    always_comb begin
        n_bad = 1'b0;
        for (int d = 0; d < 2; d++) begin
            n_p[d]     = 15'(w_year[d]) + YEAR_BIAS;
            n_q100p[d] = f_div25(n_p[d][14:2]);
            n_q400p[d] = f_div25({2'b00, n_p[d][14:4]});
            n_q100y[d] = f_div25({1'b0, w_year[d][13:2]});
            if (w_month[d] == 4'd0 || w_month[d] > MONTHS) begin
                n_bad = 1'b1;
            end
        end
    end

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            w_century[d] = ({1'b0, r1_year[d]} == 15'(r1_q100y[d]) * CENTURY);
            // century years are leap only when divisible by 400 (low four bits zero)
            w_leap[d]    = (r1_year[d][1:0] == 2'b00) &&
                           (!w_century[d] || r1_year[d][3:0] == 4'd0);
            n_base[d]    = 23'(r1_p[d]) * DAYS_IN_YEAR + 23'(r1_p[d][14:2])
                           - 23'(r1_q100p[d]) + 23'(r1_q400p[d]);
            n_add[d]     = r1_dbm[d] + 9'(r1_day[d]) + 9'(w_leap[d] && r1_late[d]);
        end
    end

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            n_n[d] = r2_base[d] + 23'(r2_add[d]);
        end
    end

    always_comb begin
        w_diff = $signed({1'b0, r3_n[1]}) - $signed({1'b0, r3_n[0]});
        if (w_diff > DIST_HI) begin
            n_dist = t_dist'(DIST_HI[22:0]);
        end else if (w_diff < DIST_LO) begin
            n_dist = t_dist'(DIST_LO[22:0]);
        end else begin
            n_dist = w_diff[22:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            o_valid  <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_bad <= n_bad;
            r2_bad <= r1_bad;
            r3_bad <= r2_bad;
            for (int d = 0; d < 2; d++) begin
                r1_p[d]     <= n_p[d];
                r1_year[d]  <= w_year[d];
                r1_q100p[d] <= n_q100p[d];
                r1_q400p[d] <= n_q400p[d][5:0];
                r1_q100y[d] <= n_q100y[d];
                r1_dbm[d]   <= f_days_before(w_month[d]);
                r1_late[d]  <= (w_month[d] > FEBRUARY);
                r1_day[d]   <= w_day[d];
                r2_base[d]  <= n_base[d];
                r2_add[d]   <= n_add[d];
                r3_n[d]     <= n_n[d];
            end
            // a bad month forces a zero distance
            o_status        <= r3_bad;
            o_distance_days <= r3_bad ? '0 : n_dist;
        end
    end

    `DDID_ASSERT_IMP(a_status_zero, i_clk, i_rst_n, o_valid && o_status, o_distance_days == '0)
    `DDID_ASSERT_IMP(a_stall_path, i_clk, i_rst_n, o_valid && i_stall, o_stall)
    `DDID_ASSERT_NXT(a_stage_move, i_clk, i_rst_n, r3_valid && en, o_valid)
    `DDID_ASSERT_NXT(a_bad_flow, i_clk, i_rst_n, r3_valid && r3_bad && en, o_status)

endmodule
